### src/cirg_pkg.sv
// Shared types, codes and reset values for the charger input restart guard.
package cirg_pkg;

    // Configuration port geometry and fixed field widths.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int LEVEL_W     = 12;
    localparam int TIME_W      = 32;
    localparam int LIMIT_W     = 16;
    localparam int BUDGET_W    = 8;

    // Item kinds; the fourth code has no meaning and changes nothing.
    typedef enum logic [1:0] {
        KIND_SAMPLE     = 2'd0,
        KIND_POLL       = 2'd1,
        KIND_INVALIDATE = 2'd2
    } t_kind;

    // Poll answers.
    typedef enum logic [1:0] {
        GRANT_DENY     = 2'd0,
        GRANT_CONTINUE = 2'd1,
        GRANT_START    = 2'd2
    } t_grant;

    // Fault codes; the fourth code is treated as no fault.
    typedef enum logic [1:0] {
        FAULT_NONE   = 2'd0,
        FAULT_ADC    = 2'd1,
        FAULT_OUTPUT = 2'd2
    } t_fault;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FRESH_LIMIT   = 3'd0,
        REG_LOSS_LEVEL    = 3'd1,
        REG_RECOVER_LEVEL = 3'd2,
        REG_STABLE_TIME   = 3'd3,
        REG_WINDOW_TIME   = 3'd4,
        REG_RESTART_LIMIT = 3'd5,
        REG_COOLDOWN_TIME = 3'd6,
        REG_PWM_RUNNING   = 3'd7
    } t_cfg_index;

    // Register reset values.
    localparam logic [LIMIT_W-1:0]  RST_FRESH_LIMIT   = 16'd50;
    localparam logic [LEVEL_W-1:0]  RST_LOSS_LEVEL    = 12'd200;
    localparam logic [LEVEL_W-1:0]  RST_RECOVER_LEVEL = 12'd400;
    localparam logic [LIMIT_W-1:0]  RST_STABLE_TIME   = 16'd500;
    localparam logic [TIME_W-1:0]   RST_WINDOW_TIME   = 32'd60000;
    localparam logic [BUDGET_W-1:0] RST_RESTART_LIMIT = 8'd3;
    localparam logic [TIME_W-1:0]   RST_COOLDOWN_TIME = 32'd300000;

    // Configuration register set.
    typedef struct packed {
        logic [LIMIT_W-1:0]  fresh_limit_ms;
        logic [LEVEL_W-1:0]  loss_level;
        logic [LEVEL_W-1:0]  recover_level;
        logic [LIMIT_W-1:0]  stable_time_ms;
        logic [TIME_W-1:0]   window_time_ms;
        logic [BUDGET_W-1:0] restart_limit;
        logic [TIME_W-1:0]   cooldown_time_ms;
        logic                pwm_running;
    } t_cfg;

    // Per-item answer and status flags after the item.
    typedef struct packed {
        logic [1:0] grant;
        logic       force_zero;
        logic       inhibited;
        logic       qualified;
        logic       cooling;
        logic [1:0] fault;
    } t_status;

endpackage

### src/cirg_cfg_regs.sv
// Configuration register file of the charger input restart guard.
module cirg_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [cirg_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [cirg_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output cirg_pkg::t_cfg                    o_cfg
);

    cirg_pkg::t_cfg r_cfg;

    // Registers load on a write strobe and return to their defaults on reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fresh_limit_ms   <= cirg_pkg::RST_FRESH_LIMIT;
            r_cfg.loss_level       <= cirg_pkg::RST_LOSS_LEVEL;
            r_cfg.recover_level    <= cirg_pkg::RST_RECOVER_LEVEL;
            r_cfg.stable_time_ms   <= cirg_pkg::RST_STABLE_TIME;
            r_cfg.window_time_ms   <= cirg_pkg::RST_WINDOW_TIME;
            r_cfg.restart_limit    <= cirg_pkg::RST_RESTART_LIMIT;
            r_cfg.cooldown_time_ms <= cirg_pkg::RST_COOLDOWN_TIME;
            r_cfg.pwm_running      <= 1'b0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                cirg_pkg::REG_FRESH_LIMIT: begin
                    r_cfg.fresh_limit_ms <= i_cfg_data[cirg_pkg::LIMIT_W-1:0];
                end
                cirg_pkg::REG_LOSS_LEVEL: begin
                    r_cfg.loss_level <= i_cfg_data[cirg_pkg::LEVEL_W-1:0];
                end
                cirg_pkg::REG_RECOVER_LEVEL: begin
                    r_cfg.recover_level <= i_cfg_data[cirg_pkg::LEVEL_W-1:0];
                end
                cirg_pkg::REG_STABLE_TIME: begin
                    r_cfg.stable_time_ms <= i_cfg_data[cirg_pkg::LIMIT_W-1:0];
                end
                cirg_pkg::REG_WINDOW_TIME: begin
                    r_cfg.window_time_ms <= i_cfg_data[cirg_pkg::TIME_W-1:0];
                end
                cirg_pkg::REG_RESTART_LIMIT: begin
                    r_cfg.restart_limit <= i_cfg_data[cirg_pkg::BUDGET_W-1:0];
                end
                cirg_pkg::REG_COOLDOWN_TIME: begin
                    r_cfg.cooldown_time_ms <= i_cfg_data[cirg_pkg::TIME_W-1:0];
                end
                cirg_pkg::REG_PWM_RUNNING: begin
                    r_cfg.pwm_running <= i_cfg_data[0];
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### src/cirg_guard.sv
// Guard state registers and the single-pass event update logic.
module cirg_guard #(
    parameter int SAMPLE_WIDTH = 12,
    parameter int TALLY_WIDTH  = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_fire,
    input  logic [1:0]                     i_kind,
    input  logic [SAMPLE_WIDTH-1:0]        i_raw_sample,
    input  logic [cirg_pkg::TIME_W-1:0]    i_time_ms,
    input  logic [1:0]                     i_fault_code,
    input  cirg_pkg::t_cfg                 i_cfg,
    output cirg_pkg::t_status              o_status,
    output logic [TALLY_WIDTH-1:0]         o_loss_count,
    output logic [TALLY_WIDTH-1:0]         o_start_count,
    output logic [TALLY_WIDTH-1:0]         o_cooldown_count
);

    localparam int CmpW = (SAMPLE_WIDTH > cirg_pkg::LEVEL_W) ? SAMPLE_WIDTH
                                                              : cirg_pkg::LEVEL_W;
    localparam int TW = cirg_pkg::TIME_W;

    // Control state.
    logic                          r_seen;
    logic                          r_inhibit;
    logic                          r_qualify;
    logic                          r_pending;
    logic                          r_win_open;
    logic                          r_cooling;
    logic [cirg_pkg::BUDGET_W-1:0] r_restarts;
    logic [1:0]                    r_fault;
    logic [TALLY_WIDTH-1:0]        r_losses;
    logic [TALLY_WIDTH-1:0]        r_starts;
    logic [TALLY_WIDTH-1:0]        r_cooldowns;

    // Time stamps, only read once their flag says they were written.
    logic [TW-1:0] r_last_sample;
    logic [TW-1:0] r_stable_start;
    logic [TW-1:0] r_win_start;
    logic [TW-1:0] r_cool_start;

    logic                          n_seen;
    logic                          n_inhibit;
    logic                          n_qualify;
    logic                          n_pending;
    logic                          n_win_open;
    logic                          n_cooling;
    logic [cirg_pkg::BUDGET_W-1:0] n_restarts;
    logic [1:0]                    n_fault;
    logic [TALLY_WIDTH-1:0]        n_losses;
    logic [TALLY_WIDTH-1:0]        n_starts;
    logic [TALLY_WIDTH-1:0]        n_cooldowns;
    logic [TW-1:0]                 n_last_sample;
    logic [TW-1:0]                 n_stable_start;
    logic [TW-1:0]                 n_win_start;
    logic [TW-1:0]                 n_cool_start;
    logic [1:0]                    n_grant;
    logic                          n_forced;

    // Wrapped time differences against each stored stamp.
    logic [TW-1:0]   gap_sample;
    logic [TW-1:0]   gap_stable;
    logic [TW-1:0]   gap_window;
    logic [TW-1:0]   gap_cool;
    logic            stale;
    logic            stable_short;
    logic            window_over;
    logic            cool_running;
    logic [CmpW-1:0] raw_ext;
    logic [CmpW-1:0] loss_ext;
    logic [CmpW-1:0] recover_ext;
    logic            raw_lost;
    logic            raw_recovered;

    assign gap_sample   = i_time_ms - r_last_sample;
    assign gap_stable   = i_time_ms - r_stable_start;
    assign gap_window   = i_time_ms - r_win_start;
    assign gap_cool     = i_time_ms - r_cool_start;
    assign stale        = gap_sample > TW'(i_cfg.fresh_limit_ms);
    assign stable_short = gap_stable < TW'(i_cfg.stable_time_ms);
    assign window_over  = gap_window >= i_cfg.window_time_ms;
    assign cool_running = gap_cool < i_cfg.cooldown_time_ms;

    assign raw_ext       = CmpW'(i_raw_sample);
    assign loss_ext      = CmpW'(i_cfg.loss_level);
    assign recover_ext   = CmpW'(i_cfg.recover_level);
    assign raw_lost      = raw_ext <= loss_ext;
    assign raw_recovered = raw_ext >= recover_ext;

    // Next state for one event. An input drop counts a loss only when power
    // was on after at least one start; stale and lost conditions in the same
    // event merge into a single drop and count at most one loss.
    always_comb begin
        logic drop;
        logic proceed;

        drop           = 1'b0;
        proceed        = 1'b0;
        n_seen         = r_seen;
        n_inhibit      = r_inhibit;
        n_qualify      = r_qualify;
        n_pending      = r_pending;
        n_win_open     = r_win_open;
        n_cooling      = r_cooling;
        n_restarts     = r_restarts;
        n_fault        = r_fault;
        n_losses       = r_losses;
        n_starts       = r_starts;
        n_cooldowns    = r_cooldowns;
        n_last_sample  = r_last_sample;
        n_stable_start = r_stable_start;
        n_win_start    = r_win_start;
        n_cool_start   = r_cool_start;
        n_grant        = cirg_pkg::GRANT_DENY;
        n_forced       = 1'b0;

        priority if (i_kind == cirg_pkg::KIND_SAMPLE) begin
            drop = r_seen && (stale || raw_lost);
            if (!r_seen && raw_lost) begin
                drop = 1'b1;
            end
        end else if (i_kind == cirg_pkg::KIND_POLL) begin
            drop = !r_seen || stale;
        end else if (i_kind == cirg_pkg::KIND_INVALIDATE) begin
            drop = 1'b1;
        end else begin
            drop = 1'b0;
        end

        // Shared input drop.
        if (drop) begin
            if (!r_inhibit && (r_starts != '0)) begin
                n_losses  = r_losses + TALLY_WIDTH'(1);
                n_pending = 1'b1;
            end
            n_inhibit = 1'b1;
            n_qualify = 1'b0;
            n_forced  = i_cfg.pwm_running;
        end

        priority if (i_kind == cirg_pkg::KIND_SAMPLE) begin
            n_seen        = 1'b1;
            n_last_sample = i_time_ms;
            if (!raw_lost && n_inhibit) begin
                if (!raw_recovered) begin
                    n_qualify = 1'b0;
                end else if (!n_qualify) begin
                    n_stable_start = i_time_ms;
                    n_qualify      = 1'b1;
                end
            end
        end else if (i_kind == cirg_pkg::KIND_POLL) begin
            if (r_fault == cirg_pkg::FAULT_NONE) begin
                // Cooldown either still holds power off or ends here.
                proceed = 1'b1;
                if (r_cooling) begin
                    if (cool_running) begin
                        proceed = 1'b0;
                    end else begin
                        n_cooling  = 1'b0;
                        n_win_open = 1'b0;
                        n_restarts = '0;
                    end
                end
                if (proceed) begin
                    if (!n_inhibit) begin
                        n_grant = cirg_pkg::GRANT_CONTINUE;
                    end else if (n_qualify && !stable_short) begin
                        // Restart budget, counted per window.
                        if (n_pending) begin
                            if (!n_win_open || window_over) begin
                                n_win_start = i_time_ms;
                                n_restarts  = '0;
                                n_win_open  = 1'b1;
                            end
                            if (n_restarts >= i_cfg.restart_limit) begin
                                n_cooling    = 1'b1;
                                n_cool_start = i_time_ms;
                                n_cooldowns  = r_cooldowns + TALLY_WIDTH'(1);
                                proceed      = 1'b0;
                            end else begin
                                n_restarts = n_restarts + cirg_pkg::BUDGET_W'(1);
                            end
                        end
                        if (proceed) begin
                            n_pending = 1'b0;
                            n_inhibit = 1'b0;
                            n_starts  = r_starts + TALLY_WIDTH'(1);
                            n_grant   = cirg_pkg::GRANT_START;
                        end
                    end
                end
            end
        end else if (i_kind == cirg_pkg::KIND_INVALIDATE) begin
            if (i_fault_code == cirg_pkg::FAULT_ADC ||
                i_fault_code == cirg_pkg::FAULT_OUTPUT) begin
                n_fault = i_fault_code;
            end
        end else begin
            n_seen = r_seen;
        end
    end

    // Control state update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen      <= 1'b0;
            r_inhibit   <= 1'b1;
            r_qualify   <= 1'b0;
            r_pending   <= 1'b0;
            r_win_open  <= 1'b0;
            r_cooling   <= 1'b0;
            r_restarts  <= '0;
            r_fault     <= cirg_pkg::FAULT_NONE;
            r_losses    <= '0;
            r_starts    <= '0;
            r_cooldowns <= '0;
        end else if (i_fire) begin
            r_seen      <= n_seen;
            r_inhibit   <= n_inhibit;
            r_qualify   <= n_qualify;
            r_pending   <= n_pending;
            r_win_open  <= n_win_open;
            r_cooling   <= n_cooling;
            r_restarts  <= n_restarts;
            r_fault     <= n_fault;
            r_losses    <= n_losses;
            r_starts    <= n_starts;
            r_cooldowns <= n_cooldowns;
        end
    end

    // Time stamp update.
    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_last_sample  <= n_last_sample;
            r_stable_start <= n_stable_start;
            r_win_start    <= n_win_start;
            r_cool_start   <= n_cool_start;
        end
    end

    assign o_status.grant      = n_grant;
    assign o_status.force_zero = n_forced;
    assign o_status.inhibited  = n_inhibit;
    assign o_status.qualified  = n_qualify;
    assign o_status.cooling    = n_cooling;
    assign o_status.fault      = n_fault;
    assign o_loss_count        = n_losses;
    assign o_start_count       = n_starts;
    assign o_cooldown_count    = n_cooldowns;

endmodule

### src/charger_input_restart_guard.sv
// Top level of the charger input restart guard: staging registers and handshakes.
// The guard takes one timestamped event per clock cycle while the output side is not
// stalled and returns exactly one result per event, offered from the result register:
// the event waits in the input register, is evaluated in a single combinational pass
// against the guard state once the result register is free or draining and lands
// in the result register at the next edge. The input register frees itself
// whenever the result register can take a new result, so transfers continue back
// to back while the output is accepted each cycle. Configuration writes take
// effect on the next cycle and are meant to be made while no event is in flight.
module charger_input_restart_guard #(
    parameter int SAMPLE_WIDTH = 12,
    parameter int TALLY_WIDTH  = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [cirg_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [cirg_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [1:0]                        i_kind,
    input  logic [SAMPLE_WIDTH-1:0]           i_raw_sample,
    input  logic [cirg_pkg::TIME_W-1:0]       i_time_ms,
    input  logic [1:0]                        i_fault_code,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [1:0]                        o_grant,
    output logic                              o_force_zero,
    output logic                              o_inhibited_now,
    output logic                              o_qualified_now,
    output logic                              o_cooling_down,
    output logic [1:0]                        o_latched_fault,
    output logic [TALLY_WIDTH-1:0]            o_loss_count,
    output logic [TALLY_WIDTH-1:0]            o_start_count,
    output logic [TALLY_WIDTH-1:0]            o_cooldown_count
);

    cirg_pkg::t_cfg    cfg;
    cirg_pkg::t_status status;
    logic [TALLY_WIDTH-1:0] loss_count;
    logic [TALLY_WIDTH-1:0] start_count;
    logic [TALLY_WIDTH-1:0] cooldown_count;

    logic                        r_in_valid;
    logic [1:0]                  r_kind;
    logic [SAMPLE_WIDTH-1:0]     r_raw_sample;
    logic [cirg_pkg::TIME_W-1:0] r_time_ms;
    logic [1:0]                  r_fault_code;

    logic                   r_out_valid;
    cirg_pkg::t_status      r_status;
    logic [TALLY_WIDTH-1:0] r_loss_count;
    logic [TALLY_WIDTH-1:0] r_start_count;
    logic [TALLY_WIDTH-1:0] r_cooldown_count;

    logic fire;
    logic in_xfer;

    // The held event is evaluated when the result register is free or draining.
    assign fire       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || fire;
    assign in_xfer    = i_in_valid && o_in_ready;

    cirg_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    cirg_guard #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .TALLY_WIDTH  (TALLY_WIDTH)
    ) u_guard (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_fire           (fire),
        .i_kind           (r_kind),
        .i_raw_sample     (r_raw_sample),
        .i_time_ms        (r_time_ms),
        .i_fault_code     (r_fault_code),
        .i_cfg            (cfg),
        .o_status         (status),
        .o_loss_count     (loss_count),
        .o_start_count    (start_count),
        .o_cooldown_count (cooldown_count)
    );

    // Input register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    // Input register payload.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_kind       <= i_kind;
            r_raw_sample <= i_raw_sample;
            r_time_ms    <= i_time_ms;
            r_fault_code <= i_fault_code;
        end
    end

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_status         <= status;
            r_loss_count     <= loss_count;
            r_start_count    <= start_count;
            r_cooldown_count <= cooldown_count;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_grant          = r_status.grant;
    assign o_force_zero     = r_status.force_zero;
    assign o_inhibited_now  = r_status.inhibited;
    assign o_qualified_now  = r_status.qualified;
    assign o_cooling_down   = r_status.cooling;
    assign o_latched_fault  = r_status.fault;
    assign o_loss_count     = r_loss_count;
    assign o_start_count    = r_start_count;
    assign o_cooldown_count = r_cooldown_count;

endmodule

### sim/tb_charger_input_restart_guard.sv
// Self-checking testbench for the charger input restart guard.
module tb_charger_input_restart_guard;

    localparam int CFG_INDEX_W    = cirg_pkg::CFG_INDEX_W;
    localparam int CFG_DATA_W     = cirg_pkg::CFG_DATA_W;
    localparam int LEVEL_W        = cirg_pkg::LEVEL_W;
    localparam int TIME_W         = cirg_pkg::TIME_W;
    localparam int LIMIT_W        = cirg_pkg::LIMIT_W;
    localparam int BUDGET_W       = cirg_pkg::BUDGET_W;
    localparam int TALLY_W        = 16;
    localparam int STALL_LIMIT    = 4000;
    localparam int LONG_HOLD      = 300;
    localparam logic [1:0] KIND_UNUSED  = 2'd3;
    localparam logic [1:0] FAULT_UNUSED = 2'd3;

    // One event as it is offered to the guard.
    typedef struct packed {
        logic [1:0]         kind;
        logic [LEVEL_W-1:0] raw;
        logic [TIME_W-1:0]  stamp;
        logic [1:0]         code;
    } t_event;

    // One expected answer of the guard.
    typedef struct packed {
        logic [1:0]         grant;
        logic               force_zero;
        logic               inhibited;
        logic               qualified;
        logic               cooling;
        logic [1:0]         fault;
        logic [TALLY_W-1:0] losses;
        logic [TALLY_W-1:0] starts;
        logic [TALLY_W-1:0] cooldowns;
    } t_outcome;

    // Clock, reset and block ports.
    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_ready;
    logic [1:0]             i_kind = '0;
    logic [LEVEL_W-1:0]     i_raw_sample = '0;
    logic [TIME_W-1:0]      i_time_ms = '0;
    logic [1:0]             i_fault_code = '0;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    logic [1:0]             o_grant;
    logic                   o_force_zero;
    logic                   o_inhibited_now;
    logic                   o_qualified_now;
    logic                   o_cooling_down;
    logic [1:0]             o_latched_fault;
    logic [TALLY_W-1:0]     o_loss_count;
    logic [TALLY_W-1:0]     o_start_count;
    logic [TALLY_W-1:0]     o_cooldown_count;

    charger_input_restart_guard u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_kind           (i_kind),
        .i_raw_sample     (i_raw_sample),
        .i_time_ms        (i_time_ms),
        .i_fault_code     (i_fault_code),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_grant          (o_grant),
        .o_force_zero     (o_force_zero),
        .o_inhibited_now  (o_inhibited_now),
        .o_qualified_now  (o_qualified_now),
        .o_cooling_down   (o_cooling_down),
        .o_latched_fault  (o_latched_fault),
        .o_loss_count     (o_loss_count),
        .o_start_count    (o_start_count),
        .o_cooldown_count (o_cooldown_count)
    );

    // Free-running clock.
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Shared testbench state.
    t_outcome          answers_due[$];
    int                mismatches    = 0;
    int                send_idle_pct = 0;
    int                recv_idle_pct = 0;
    int                hold_request  = 0;
    int                hold_left     = 0;
    int                quiet_cycles  = 0;
    int                step_max      = 10;
    int                fault_pct     = 0;
    logic [TIME_W-1:0] clock_cursor  = '0;

    // Own copy of the guard configuration and state.
    cirg_pkg::t_cfg      grd_cfg;
    logic                grd_seen;
    logic [TIME_W-1:0]   grd_last_sample;
    logic                grd_inhibit;
    logic                grd_qualify;
    logic [TIME_W-1:0]   grd_stable_start;
    logic                grd_pending;
    logic                grd_win_open;
    logic [TIME_W-1:0]   grd_win_start;
    logic [BUDGET_W-1:0] grd_restarts;
    logic                grd_cooling;
    logic [TIME_W-1:0]   grd_cool_start;
    logic [1:0]          grd_fault;
    logic [TALLY_W-1:0]  grd_losses;
    logic [TALLY_W-1:0]  grd_starts;
    logic [TALLY_W-1:0]  grd_cooldowns;
    logic                grd_forced;

    // Put the guard copy into its post-reset condition.
    function automatic void reset_guard_copy();
        grd_cfg.fresh_limit_ms   = cirg_pkg::RST_FRESH_LIMIT;
        grd_cfg.loss_level       = cirg_pkg::RST_LOSS_LEVEL;
        grd_cfg.recover_level    = cirg_pkg::RST_RECOVER_LEVEL;
        grd_cfg.stable_time_ms   = cirg_pkg::RST_STABLE_TIME;
        grd_cfg.window_time_ms   = cirg_pkg::RST_WINDOW_TIME;
        grd_cfg.restart_limit    = cirg_pkg::RST_RESTART_LIMIT;
        grd_cfg.cooldown_time_ms = cirg_pkg::RST_COOLDOWN_TIME;
        grd_cfg.pwm_running      = 1'b0;
        grd_seen         = 1'b0;
        grd_last_sample  = '0;
        grd_inhibit      = 1'b1;
        grd_qualify      = 1'b0;
        grd_stable_start = '0;
        grd_pending      = 1'b0;
        grd_win_open     = 1'b0;
        grd_win_start    = '0;
        grd_restarts     = '0;
        grd_cooling      = 1'b0;
        grd_cool_start   = '0;
        grd_fault        = cirg_pkg::FAULT_NONE;
        grd_losses       = '0;
        grd_starts       = '0;
        grd_cooldowns    = '0;
        grd_forced       = 1'b0;
    endfunction

    // Input goes away: a loss is counted only while power is on after at least one grant.
    function automatic void lose_input();
        if (!grd_inhibit && grd_starts != 0) begin
            grd_losses  = grd_losses + TALLY_W'(1);
            grd_pending = 1'b1;
        end
        grd_inhibit = 1'b1;
        grd_qualify = 1'b0;
        if (grd_cfg.pwm_running) grd_forced = 1'b1;
    endfunction

    // Work out the guard's answer to one event and advance its state.
    function automatic t_outcome guard_answer(t_event ev);
        t_outcome          res;
        logic [TIME_W-1:0] since_sample;
        logic [TIME_W-1:0] since_stable;
        logic [TIME_W-1:0] since_cool;
        logic [TIME_W-1:0] since_window;
        logic              settled;
        logic [1:0]        grant;

        grant        = cirg_pkg::GRANT_DENY;
        settled      = 1'b0;
        grd_forced   = 1'b0;
        since_sample = ev.stamp - grd_last_sample;
        case (ev.kind)
            cirg_pkg::KIND_SAMPLE: begin
                if (grd_seen && since_sample > {16'd0, grd_cfg.fresh_limit_ms})
                    lose_input();
                grd_seen        = 1'b1;
                grd_last_sample = ev.stamp;
                if (ev.raw <= grd_cfg.loss_level) begin
                    lose_input();
                end else if (grd_inhibit) begin
                    if (ev.raw < grd_cfg.recover_level) begin
                        grd_qualify = 1'b0;
                    end else if (!grd_qualify) begin
                        grd_stable_start = ev.stamp;
                        grd_qualify      = 1'b1;
                    end
                end
            end
            cirg_pkg::KIND_POLL: begin
                if (!grd_seen || since_sample > {16'd0, grd_cfg.fresh_limit_ms})
                    lose_input();
                since_cool   = ev.stamp - grd_cool_start;
                since_stable = ev.stamp - grd_stable_start;
                since_window = ev.stamp - grd_win_start;
                // A latched fault or a running cooldown denies outright.
                if (grd_fault != cirg_pkg::FAULT_NONE) begin
                    settled = 1'b1;
                end else if (grd_cooling) begin
                    if (since_cool < grd_cfg.cooldown_time_ms) begin
                        settled = 1'b1;
                    end else begin
                        grd_cooling  = 1'b0;
                        grd_win_open = 1'b0;
                        grd_restarts = '0;
                    end
                end
                if (!settled) begin
                    if (!grd_inhibit) begin
                        grant = cirg_pkg::GRANT_CONTINUE;
                    end else if (grd_qualify &&
                                 since_stable >= {16'd0, grd_cfg.stable_time_ms}) begin
                        // A restart is charged against the current window.
                        if (grd_pending) begin
                            if (!grd_win_open || since_window >= grd_cfg.window_time_ms) begin
                                grd_win_start = ev.stamp;
                                grd_restarts  = '0;
                                grd_win_open  = 1'b1;
                            end
                            if (grd_restarts >= grd_cfg.restart_limit) begin
                                grd_cooling    = 1'b1;
                                grd_cool_start = ev.stamp;
                                grd_cooldowns  = grd_cooldowns + TALLY_W'(1);
                                settled        = 1'b1;
                            end else begin
                                grd_restarts = grd_restarts + BUDGET_W'(1);
                            end
                        end
                        if (!settled) begin
                            grd_pending = 1'b0;
                            grd_inhibit = 1'b0;
                            grd_starts  = grd_starts + TALLY_W'(1);
                            grant       = cirg_pkg::GRANT_START;
                        end
                    end
                end
            end
            cirg_pkg::KIND_INVALIDATE: begin
                lose_input();
                if (ev.code == cirg_pkg::FAULT_ADC || ev.code == cirg_pkg::FAULT_OUTPUT)
                    grd_fault = ev.code;
            end
            default: begin
            end
        endcase
        res.grant      = grant;
        res.force_zero = grd_forced;
        res.inhibited  = grd_inhibit;
        res.qualified  = grd_qualify;
        res.cooling    = grd_cooling;
        res.fault      = grd_fault;
        res.losses     = grd_losses;
        res.starts     = grd_starts;
        res.cooldowns  = grd_cooldowns;
        return res;
    endfunction

    function automatic t_event make_event(logic [1:0] kind, logic [LEVEL_W-1:0] raw,
                                          logic [TIME_W-1:0] stamp, logic [1:0] code);
        t_event ev;
        ev.kind  = kind;
        ev.raw   = raw;
        ev.stamp = stamp;
        ev.code  = code;
        return ev;
    endfunction

    function automatic cirg_pkg::t_cfg make_settings(int fresh, int loss, int recover,
                                                     int stable,
                                                     logic [TIME_W-1:0] window, int budget,
                                                     logic [TIME_W-1:0] cooldown, bit pwm);
        cirg_pkg::t_cfg c;
        c.fresh_limit_ms   = fresh[LIMIT_W-1:0];
        c.loss_level       = loss[LEVEL_W-1:0];
        c.recover_level    = recover[LEVEL_W-1:0];
        c.stable_time_ms   = stable[LIMIT_W-1:0];
        c.window_time_ms   = window;
        c.restart_limit    = budget[BUDGET_W-1:0];
        c.cooldown_time_ms = cooldown;
        c.pwm_running      = pwm;
        return c;
    endfunction

    // Random event on a mostly fresh time line, with occasional jumps and wraps.
    function automatic t_event random_event();
        t_event ev;
        int     pick;
        int     lvl_lo;
        int     lvl_hi;

        if ($urandom_range(99) < 1)
            clock_cursor = 32'hFFFF_FFFF - $urandom_range(0, 300);
        else if ($urandom_range(99) < 4)
            clock_cursor = clock_cursor + $urandom;
        else
            clock_cursor = clock_cursor + $urandom_range(0, step_max);
        ev.stamp = clock_cursor;

        pick = $urandom_range(99);
        if (pick < 55)      ev.kind = cirg_pkg::KIND_SAMPLE;
        else if (pick < 88) ev.kind = cirg_pkg::KIND_POLL;
        else if (pick < 94) ev.kind = cirg_pkg::KIND_INVALIDATE;
        else                ev.kind = KIND_UNUSED;

        // Readings mostly healthy, some marginal, some lost.
        lvl_lo = grd_cfg.loss_level;
        lvl_hi = grd_cfg.recover_level;
        pick   = $urandom_range(99);
        if (pick < 70)
            ev.raw = LEVEL_W'($urandom_range(lvl_hi, 4095));
        else if (pick < 80 && lvl_hi > lvl_lo + 1)
            ev.raw = LEVEL_W'($urandom_range(lvl_lo + 1, lvl_hi - 1));
        else if (pick < 88)
            ev.raw = LEVEL_W'($urandom_range(0, lvl_lo));
        else if (pick < 94)
            ev.raw = LEVEL_W'($urandom);
        else if (pick < 97)
            ev.raw = '0;
        else
            ev.raw = '1;

        if ($urandom_range(99) < fault_pct)
            ev.code = 2'($urandom_range(cirg_pkg::FAULT_ADC, cirg_pkg::FAULT_OUTPUT));
        else
            ev.code = $urandom_range(1) ? FAULT_UNUSED : cirg_pkg::FAULT_NONE;
        return ev;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // Offer one event and record its expected answer on transfer.
    task automatic send_event(t_event ev);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid   <= 1'b1;
        i_kind       <= ev.kind;
        i_raw_sample <= ev.raw;
        i_time_ms    <= ev.stamp;
        i_fault_code <= ev.code;
        do @(posedge i_clk); while (!o_in_ready);
        answers_due.push_back(guard_answer(ev));
    endtask

    task automatic send_random(int count);
        repeat (count) send_event(random_event());
        i_in_valid <= 1'b0;
    endtask

    task automatic wait_for_answers();
        while (answers_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(cirg_pkg::t_cfg_index idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            cirg_pkg::REG_FRESH_LIMIT:   grd_cfg.fresh_limit_ms   = data[LIMIT_W-1:0];
            cirg_pkg::REG_LOSS_LEVEL:    grd_cfg.loss_level       = data[LEVEL_W-1:0];
            cirg_pkg::REG_RECOVER_LEVEL: grd_cfg.recover_level    = data[LEVEL_W-1:0];
            cirg_pkg::REG_STABLE_TIME:   grd_cfg.stable_time_ms   = data[LIMIT_W-1:0];
            cirg_pkg::REG_WINDOW_TIME:   grd_cfg.window_time_ms   = data;
            cirg_pkg::REG_RESTART_LIMIT: grd_cfg.restart_limit    = data[BUDGET_W-1:0];
            cirg_pkg::REG_COOLDOWN_TIME: grd_cfg.cooldown_time_ms = data;
            cirg_pkg::REG_PWM_RUNNING:   grd_cfg.pwm_running      = data[0];
            default: begin
            end
        endcase
        @(posedge i_clk);
    endtask

    task automatic apply_settings(cirg_pkg::t_cfg c);
        write_reg(cirg_pkg::REG_FRESH_LIMIT,   {16'd0, c.fresh_limit_ms});
        write_reg(cirg_pkg::REG_LOSS_LEVEL,    {20'd0, c.loss_level});
        write_reg(cirg_pkg::REG_RECOVER_LEVEL, {20'd0, c.recover_level});
        write_reg(cirg_pkg::REG_STABLE_TIME,   {16'd0, c.stable_time_ms});
        write_reg(cirg_pkg::REG_WINDOW_TIME,   c.window_time_ms);
        write_reg(cirg_pkg::REG_RESTART_LIMIT, {24'd0, c.restart_limit});
        write_reg(cirg_pkg::REG_COOLDOWN_TIME, c.cooldown_time_ms);
        write_reg(cirg_pkg::REG_PWM_RUNNING,   {31'd0, c.pwm_running});
    endtask

    // Hand-picked events: unused kind, early poll, first start, losses, restart
    // budget, cooldown expiry, unused fault code and time wrap.
    task automatic test_directed_cases();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_event(make_event(KIND_UNUSED, '1, 32'd0, cirg_pkg::FAULT_NONE));
        send_event(make_event(cirg_pkg::KIND_POLL, '0, 32'd0, cirg_pkg::FAULT_NONE));
        i_in_valid <= 1'b0;
        wait_for_answers();
        apply_settings(make_settings(100, 200, 400, 20, 32'd1000, 1, 32'd50, 1'b1));
        send_event(make_event(cirg_pkg::KIND_SAMPLE, 12'd0, 32'd1, cirg_pkg::FAULT_NONE));
        send_event(make_event(cirg_pkg::KIND_SAMPLE, 12'd4095, 32'd2, cirg_pkg::FAULT_NONE));
        send_event(make_event(cirg_pkg::KIND_POLL, '0, 32'd10, cirg_pkg::FAULT_NONE));
        send_event(make_event(cirg_pkg::KIND_POLL, '0, 32'd30, cirg_pkg::FAULT_NONE));
        send_event(make_event(cirg_pkg::KIND_POLL, '0, 32'd40, cirg_pkg::FAULT_NONE));
        send_event(make_event(cirg_pkg::KIND_SAMPLE, 12'd200, 32'd50, cirg_pkg::FAULT_NONE));
        send_event(make_event(cirg_pkg::KIND_SAMPLE, 12'd4095, 32'd60, cirg_pkg::FAULT_NONE));
        send_event(make_event(cirg_pkg::KIND_POLL, '0, 32'd90, cirg_pkg::FAULT_NONE));
        send_event(make_event(cirg_pkg::KIND_SAMPLE, 12'd4095, 32'd400, cirg_pkg::FAULT_NONE));
        send_event(make_event(cirg_pkg::KIND_POLL, '0, 32'd430, cirg_pkg::FAULT_NONE));
        send_event(make_event(cirg_pkg::KIND_SAMPLE, 12'd4095, 32'd440, cirg_pkg::FAULT_NONE));
        send_event(make_event(cirg_pkg::KIND_POLL, '0, 32'd450, cirg_pkg::FAULT_NONE));
        send_event(make_event(cirg_pkg::KIND_POLL, '0, 32'd485, cirg_pkg::FAULT_NONE));
        send_event(make_event(cirg_pkg::KIND_INVALIDATE, '0, 32'd490, FAULT_UNUSED));
        send_event(make_event(cirg_pkg::KIND_INVALIDATE, '0, 32'd491, cirg_pkg::FAULT_NONE));
        send_event(make_event(cirg_pkg::KIND_SAMPLE, 12'd4095, 32'hFFFF_FFF0,
                              cirg_pkg::FAULT_NONE));
        send_event(make_event(cirg_pkg::KIND_POLL, '0, 32'h0000_0010, cirg_pkg::FAULT_NONE));
        send_event(make_event(cirg_pkg::KIND_SAMPLE, 12'd300, 32'h0000_0020,
                              cirg_pkg::FAULT_NONE));
        send_event(make_event(cirg_pkg::KIND_SAMPLE, 12'd201, 32'h0000_0030,
                              cirg_pkg::FAULT_NONE));
        i_in_valid <= 1'b0;
        wait_for_answers();
    endtask

    // Restart counting and cooldowns under moderate settings.
    task automatic test_restart_window();
        apply_settings(make_settings(100, 200, 400, 30, 32'd500, 2, 32'd200, 1'b1));
        send_idle_pct = 24;
        recv_idle_pct = 55;
        step_max      = 60;
        clock_cursor  = $urandom;
        send_random(600);
        wait_for_answers();
    endtask

    // All registers at their lowest and then at their highest values.
    task automatic test_extreme_settings();
        send_idle_pct = 55;
        recv_idle_pct = 24;
        apply_settings(make_settings(0, 0, 0, 0, 32'd0, 0, 32'd0, 1'b0));
        step_max = 3;
        send_random(200);
        wait_for_answers();
        apply_settings(make_settings(65535, 4095, 4095, 65535, 32'hFFFF_FFFF, 255,
                                     32'hFFFF_FFFF, 1'b1));
        step_max = 1000;
        send_random(200);
        wait_for_answers();
    endtask

    // Back-to-back transfers with mid-range random settings.
    task automatic test_full_rate();
        int loss;

        loss = $urandom_range(0, 1000);
        apply_settings(make_settings(1000, loss, loss + $urandom_range(0, 1500),
                                     $urandom_range(0, 200), 32'd2000, $urandom_range(0, 4),
                                     $urandom_range(0, 1500), 1'($urandom_range(1))));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        step_max      = 300;
        send_random(500);
        wait_for_answers();
    endtask

    // Receiver holds off long enough for the guard to fill and stall its input.
    task automatic test_output_stall();
        apply_settings(make_settings(100, 200, 400, 30, 32'd500, 1, 32'd200, 1'b0));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        step_max      = 60;
        hold_request  = LONG_HOLD;
        send_random(40);
        wait_for_answers();
        recv_idle_pct = 30;
        send_random(40);
        wait_for_answers();
    endtask

    // Fault codes latch and a later fault replaces the earlier one.
    task automatic test_fault_latch();
        apply_settings(make_settings(100, 200, 400, 30, 32'd500, 2, 32'd200, 1'b1));
        send_idle_pct = 24;
        recv_idle_pct = 24;
        send_event(make_event(cirg_pkg::KIND_INVALIDATE, '0, clock_cursor,
                              cirg_pkg::FAULT_ADC));
        send_event(make_event(cirg_pkg::KIND_INVALIDATE, '0, clock_cursor + 1,
                              cirg_pkg::FAULT_NONE));
        send_event(make_event(cirg_pkg::KIND_INVALIDATE, '0, clock_cursor + 2,
                              cirg_pkg::FAULT_OUTPUT));
        send_event(make_event(cirg_pkg::KIND_INVALIDATE, '0, clock_cursor + 3, FAULT_UNUSED));
        send_event(make_event(cirg_pkg::KIND_POLL, '0, clock_cursor + 4,
                              cirg_pkg::FAULT_NONE));
        fault_pct = 50;
        send_random(40);
        wait_for_answers();
    endtask

    // Receiver: random back-pressure, plus a long hold-off when asked for.
    always @(posedge i_clk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left   = hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Compare each result transfer with the oldest expected answer.
    always @(posedge i_clk) begin
        t_outcome want;

        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (answers_due.size() == 0) begin
                report_mismatch("result without expectation, grant", o_grant, 0);
            end else begin
                want = answers_due.pop_front();
                if (o_grant !== want.grant) report_mismatch("grant", o_grant, want.grant);
                if (o_force_zero !== want.force_zero)
                    report_mismatch("force_zero", o_force_zero, want.force_zero);
                if (o_inhibited_now !== want.inhibited)
                    report_mismatch("inhibited_now", o_inhibited_now, want.inhibited);
                if (o_qualified_now !== want.qualified)
                    report_mismatch("qualified_now", o_qualified_now, want.qualified);
                if (o_cooling_down !== want.cooling)
                    report_mismatch("cooling_down", o_cooling_down, want.cooling);
                if (o_latched_fault !== want.fault)
                    report_mismatch("latched_fault", o_latched_fault, want.fault);
                if (o_loss_count !== want.losses)
                    report_mismatch("loss_count", o_loss_count, want.losses);
                if (o_start_count !== want.starts)
                    report_mismatch("start_count", o_start_count, want.starts);
                if (o_cooldown_count !== want.cooldowns)
                    report_mismatch("cooldown_count", o_cooldown_count, want.cooldowns);
            end
        end
    end

    // Watchdog: give up when neither side has transferred for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog expired with %0d results outstanding", answers_due.size());
            $display("charger_input_restart_guard regression: fail");
            $finish;
        end
    end

    // Test sequence.
    initial begin
        reset_guard_copy();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);
        test_directed_cases();
        test_restart_window();
        test_extreme_settings();
        test_full_rate();
        test_output_stall();
        test_fault_latch();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && answers_due.size() == 0) begin
            $display("charger_input_restart_guard regression: pass");
        end else begin
            $display("charger_input_restart_guard regression: fail");
        end
        $finish;
    end

endmodule

### sim.f
src/cirg_pkg.sv
src/cirg_cfg_regs.sv
src/cirg_guard.sv
src/charger_input_restart_guard.sv
sim/tb_charger_input_restart_guard.sv
